/* src/lef_pkg.sv */
// Package for the LED envelope follower: widths, reset values, codes and payload types.
// Used by lef_dp, lef_ctrl and level_led_envelope_follower; depends on nothing.
`default_nettype none

package lef_pkg;

  // Field widths
  localparam int SAMPLE_WIDTH = 16;
  localparam int LEVEL_WIDTH  = 8;
  localparam int TENTHS_WIDTH = 4;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = SAMPLE_WIDTH;
  localparam int PROD_WIDTH = SAMPLE_WIDTH + LEVEL_WIDTH;
  localparam int CNT_WIDTH  = $clog2(LEVEL_WIDTH);

  // Register reset values
  localparam logic [SAMPLE_WIDTH-1:0] NOISE_GATE_RST     = SAMPLE_WIDTH'(500);
  localparam logic [SAMPLE_WIDTH-1:0] FULL_SCALE_RST     = SAMPLE_WIDTH'(8000);
  localparam logic [LEVEL_WIDTH-1:0]  BRIGHTNESS_CAP_RST = LEVEL_WIDTH'(200);
  localparam logic [TENTHS_WIDTH-1:0] ATTACK_RST         = TENTHS_WIDTH'(5);
  localparam logic [TENTHS_WIDTH-1:0] RELEASE_RST        = TENTHS_WIDTH'(2);

  // Tenths saturate at ten; the step is divided by ten
  localparam logic [TENTHS_WIDTH-1:0] TENTHS_MAX  = TENTHS_WIDTH'(10);
  localparam logic [SAMPLE_WIDTH-1:0] DIVISOR_TEN = SAMPLE_WIDTH'(10);

  // Last divider step count
  localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(LEVEL_WIDTH - 1);

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_NOISE_GATE     = 3'd0,
    CFG_FULL_SCALE     = 3'd1,
    CFG_BRIGHTNESS_CAP = 3'd2,
    CFG_ATTACK_TENTHS  = 3'd3,
    CFG_RELEASE_TENTHS = 3'd4
  } lef_cfg_e;

  // Request operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ENABLE = 1'b1;

  // Result cause codes
  localparam logic CAUSE_SAMPLE = 1'b0;
  localparam logic CAUSE_OFF    = 1'b1;

  // Input request
  typedef struct packed {
    logic                    operation;
    logic [SAMPLE_WIDTH-1:0] rms;
    logic                    enable;
  } lef_in_t;

  // Output request
  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] brightness;
    logic                   cause;
  } lef_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // latch the sample
    logic set_en;      // take the new enable state
    logic clear_level; // zero the kept level
    logic tgt_zero;    // target is zero
    logic tgt_cap;     // target is the cap
    logic mul_tgt;     // product of gate offset and cap
    logic mul_step;    // product of level difference and tenths
    logic div_start;   // load the divider
    logic div_ten;     // divide by ten instead of the span
    logic div_step;    // one quotient bit
    logic apply;       // write new level and result
    logic out_off;     // write the turned-off result
  } lef_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op;       // operation of the offered request
    logic en_bit;   // enable bit of the offered request
    logic enabled;  // kept enable state
    logic tgt_zero; // sample at or below gate, or empty span
    logic tgt_sat;  // sample at or above full scale
  } lef_sts_t;

endpackage

`default_nettype wire

/* src/lef_dp.sv */
// Datapath of the LED envelope follower: config registers, kept state, shared
// multiplier and restoring divider, output register. Depends on lef_pkg.
`default_nettype none

module lef_dp (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [lef_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire  [lef_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  wire  lef_pkg::lef_in_t                in_data,
  input  wire  lef_pkg::lef_cmd_t               cmd,
  output lef_pkg::lef_sts_t                     sts,
  output lef_pkg::lef_out_t                     out_data
);

  localparam int SW = lef_pkg::SAMPLE_WIDTH;
  localparam int LW = lef_pkg::LEVEL_WIDTH;
  localparam int TW = lef_pkg::TENTHS_WIDTH;
  localparam int PW = lef_pkg::PROD_WIDTH;

  // Configuration registers
  logic [SW-1:0] noise_gate;
  logic [SW-1:0] full_scale;
  logic [LW-1:0] brightness_cap;
  logic [TW-1:0] attack_tenths;
  logic [TW-1:0] release_tenths;

  // Kept state
  logic          enabled;
  logic [LW-1:0] level;

  // Working registers
  logic [SW-1:0] rms;
  logic [PW-1:0] prod;
  logic [SW-1:0] rem;
  logic [LW-1:0] nbits;
  logic [SW-1:0] divisor;
  logic [LW-1:0] quo;       // target, then step size
  logic          rising;

  // Sample mapping
  logic          above_gate;
  logic          span_pos;
  logic [SW-1:0] gate_off;
  logic [SW-1:0] span;

  // Step computation
  logic          rise_now;
  logic [LW-1:0] mag;
  logic [TW-1:0] tenths_sel;
  logic [TW-1:0] tenths_lim;

  // Multiplier and divider
  logic [SW-1:0] mul_a;
  logic [LW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic [SW:0]   trial;
  logic [SW:0]   trial_sub;
  logic          fits;

  // Level update
  logic [LW:0]   sum;
  logic [LW-1:0] level_next;

  // Gate and span checks
  always_comb begin
    above_gate = rms > noise_gate;
    span_pos   = full_scale > noise_gate;
    gate_off   = rms - noise_gate;
    span       = full_scale - noise_gate;
  end

  assign sts.op       = in_data.operation;
  assign sts.en_bit   = in_data.enable;
  assign sts.enabled  = enabled;
  assign sts.tgt_zero = !above_gate || !span_pos;
  assign sts.tgt_sat  = gate_off >= span;

  // Direction, size and rate of the move toward the target
  always_comb begin
    rise_now   = quo > level;
    mag        = rise_now ? (quo - level) : (level - quo);
    tenths_sel = rise_now ? attack_tenths : release_tenths;
    tenths_lim = (tenths_sel > lef_pkg::TENTHS_MAX) ? lef_pkg::TENTHS_MAX : tenths_sel;
  end

  // Shared multiplier
  always_comb begin
    if (cmd.mul_tgt) begin
      mul_a = gate_off;
      mul_b = brightness_cap;
    end else begin
      mul_a = SW'(mag);
      mul_b = LW'(tenths_lim);
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // Restoring divider step; remainder stays below the divisor
  always_comb begin
    trial     = {rem, nbits[LW-1]};
    trial_sub = trial - {1'b0, divisor};
    fits      = trial >= {1'b0, divisor};
  end

  // New level, clamped to the cap
  always_comb begin
    if (rising) begin
      sum = {1'b0, level} + {1'b0, quo};
    end else begin
      sum = {1'b0, level} - {1'b0, quo};
    end
    level_next = (sum > {1'b0, brightness_cap}) ? brightness_cap : sum[LW-1:0];
  end

  // Configuration and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_gate     <= lef_pkg::NOISE_GATE_RST;
      full_scale     <= lef_pkg::FULL_SCALE_RST;
      brightness_cap <= lef_pkg::BRIGHTNESS_CAP_RST;
      attack_tenths  <= lef_pkg::ATTACK_RST;
      release_tenths <= lef_pkg::RELEASE_RST;
      enabled        <= 1'b0;
      level          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lef_pkg::CFG_NOISE_GATE:     noise_gate     <= cfg_data[SW-1:0];
          lef_pkg::CFG_FULL_SCALE:     full_scale     <= cfg_data[SW-1:0];
          lef_pkg::CFG_BRIGHTNESS_CAP: brightness_cap <= cfg_data[LW-1:0];
          lef_pkg::CFG_ATTACK_TENTHS:  attack_tenths  <= cfg_data[TW-1:0];
          lef_pkg::CFG_RELEASE_TENTHS: release_tenths <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
      if (cmd.set_en) begin
        enabled <= in_data.enable;
      end
      if (cmd.clear_level) begin
        level <= '0;
      end else if (cmd.apply) begin
        level <= level_next;
      end
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rms <= in_data.rms;
    end
    if (cmd.mul_tgt || cmd.mul_step) begin
      prod <= mul_p;
    end
    if (cmd.mul_step) begin
      rising <= rise_now;
    end
    if (cmd.div_start) begin
      rem     <= prod[PW-1:LW];
      nbits   <= prod[LW-1:0];
      divisor <= cmd.div_ten ? lef_pkg::DIVISOR_TEN : span;
    end else if (cmd.div_step) begin
      rem   <= fits ? trial_sub[SW-1:0] : trial[SW-1:0];
      nbits <= {nbits[LW-2:0], 1'b0};
    end
    if (cmd.tgt_zero) begin
      quo <= '0;
    end else if (cmd.tgt_cap) begin
      quo <= brightness_cap;
    end else if (cmd.div_step) begin
      quo <= {quo[LW-2:0], fits};
    end
    if (cmd.apply) begin
      out_data.brightness <= level_next;
      out_data.cause      <= lef_pkg::CAUSE_SAMPLE;
    end else if (cmd.out_off) begin
      out_data.brightness <= '0;
      out_data.cause      <= lef_pkg::CAUSE_OFF;
    end
  end

endmodule

`default_nettype wire

/* src/lef_ctrl.sv */
// Controller of the LED envelope follower: sequences map, divide, step and
// output phases and owns the handshake state. Depends on lef_pkg.
`default_nettype none

module lef_ctrl (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire                      out_stall,
  input  wire  lef_pkg::lef_sts_t  sts,
  output lef_pkg::lef_cmd_t        cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_LOADT,
    ST_DIVT,
    ST_STEP,
    ST_LOADS,
    ST_DIVS,
    ST_APPLY,
    ST_OFF
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [lef_pkg::CNT_WIDTH-1:0] cnt;
  logic                          slot_free;
  logic                          load_out;

  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign load_out  = cmd.apply || cmd.out_off;

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.op == lef_pkg::OP_ENABLE) begin
            cmd.set_en = 1'b1;
            if (!sts.en_bit) begin
              cmd.clear_level = 1'b1;
              state_next      = ST_OFF;
            end
          end else if (sts.enabled) begin
            state_next = ST_MAP;
          end
        end
      end
      ST_MAP: begin
        if (sts.tgt_zero) begin
          cmd.tgt_zero = 1'b1;
          state_next   = ST_STEP;
        end else if (sts.tgt_sat) begin
          cmd.tgt_cap = 1'b1;
          state_next  = ST_STEP;
        end else begin
          cmd.mul_tgt = 1'b1;
          state_next  = ST_LOADT;
        end
      end
      ST_LOADT: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVT;
      end
      ST_DIVT: begin
        cmd.div_step = 1'b1;
        if (cnt == lef_pkg::DIV_LAST) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd.mul_step = 1'b1;
        state_next   = ST_LOADS;
      end
      ST_LOADS: begin
        cmd.div_start = 1'b1;
        cmd.div_ten   = 1'b1;
        state_next    = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        if (cnt == lef_pkg::DIV_LAST) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (slot_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_OFF: begin
        if (slot_free) begin
          cmd.out_off = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_start) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // Divider runs exactly one quotient bit per level bit
  a_divt_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVT && cnt == lef_pkg::DIV_LAST) |=> (state == ST_STEP))
    else $error("target divide did not end after the last step");

  // A level result is presented as soon as the output slot is free
  a_apply_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && slot_free) |=> (out_valid && state == ST_IDLE))
    else $error("level result not presented");

  // Turning off always leaves the block disabled
  a_off_disabled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OFF) |-> !sts.enabled)
    else $error("turn-off result while still enabled");

  // A sample while disabled is dropped and the controller stays idle
  a_drop_sample: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && sts.op == lef_pkg::OP_SAMPLE && !sts.enabled)
      |=> (state == ST_IDLE))
    else $error("sample while disabled was processed");
`endif

endmodule

`default_nettype wire

/* src/level_led_envelope_follower.sv */
// Top level of the LED envelope follower: joins controller and datapath.
// Depends on lef_pkg, lef_ctrl and lef_dp.
`default_nettype none

// Attack/release envelope follower turning RMS audio levels into a white LED
// brightness. Each request is a level sample or an enable change. An enabled
// sample runs through the shared restoring divider, which yields one quotient
// bit a cycle, first for the gate-to-full-scale mapping and then for the
// division by ten of the attack/release step; the mapping division is skipped
// when the sample sits at or below the noise gate or at or above full scale.
// A disable emits brightness 0 with cause 1; an enable or a sample while
// disabled emits nothing. A finished result sits in the output register
// while the next request is accepted. Configuration writes are taken at any
// time but belong in idle periods.
module level_led_envelope_follower (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [lef_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire  [lef_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  lef_pkg::lef_in_t               in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output lef_pkg::lef_out_t                    out_data
);

  lef_pkg::lef_cmd_t cmd;
  lef_pkg::lef_sts_t sts;

  // Sequencer
  lef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state
  lef_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for level_led_envelope_follower: directed and random level and enable requests
// checked against a behavioral envelope predictor held in a small scoreboard class.
// Depends on lef_pkg and level_led_envelope_follower.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 30;   // longer than the longest unstalled request
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 53;

  // Envelope predictor and queue of expected LED levels
  class level_scoreboard;
    logic [lef_pkg::SAMPLE_WIDTH-1:0] gate;
    logic [lef_pkg::SAMPLE_WIDTH-1:0] full;
    logic [lef_pkg::LEVEL_WIDTH-1:0]  cap;
    logic [lef_pkg::TENTHS_WIDTH-1:0] attack;
    logic [lef_pkg::TENTHS_WIDTH-1:0] release_t;
    logic                             on;
    logic [lef_pkg::LEVEL_WIDTH-1:0]  level;
    lef_pkg::lef_out_t                levels_q[$];
    int                               errors;

    function new();
      gate      = lef_pkg::NOISE_GATE_RST;
      full      = lef_pkg::FULL_SCALE_RST;
      cap       = lef_pkg::BRIGHTNESS_CAP_RST;
      attack    = lef_pkg::ATTACK_RST;
      release_t = lef_pkg::RELEASE_RST;
      on        = 1'b0;
      level     = '0;
      errors    = 0;
    endfunction

    // Register writes keep only the low bits of each register
    function void set_reg(lef_pkg::lef_cfg_e idx, logic [lef_pkg::CFG_DATA_WIDTH-1:0] data);
      case (idx)
        lef_pkg::CFG_NOISE_GATE:     gate      = data[lef_pkg::SAMPLE_WIDTH-1:0];
        lef_pkg::CFG_FULL_SCALE:     full      = data[lef_pkg::SAMPLE_WIDTH-1:0];
        lef_pkg::CFG_BRIGHTNESS_CAP: cap       = data[lef_pkg::LEVEL_WIDTH-1:0];
        lef_pkg::CFG_ATTACK_TENTHS:  attack    = data[lef_pkg::TENTHS_WIDTH-1:0];
        lef_pkg::CFG_RELEASE_TENTHS: release_t = data[lef_pkg::TENTHS_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Linear gate-to-full-scale map, clamped to the cap
    function longint target_level(logic [lef_pkg::SAMPLE_WIDTH-1:0] rms);
      longint r_i, g_i, f_i, c_i, v;
      r_i = rms;
      g_i = gate;
      f_i = full;
      c_i = cap;
      if (r_i <= g_i || f_i <= g_i) return 0;
      v = ((r_i - g_i) * c_i) / (f_i - g_i);
      if (v > c_i) v = c_i;
      return v;
    endfunction

    // Update kept state for an accepted request and queue any result
    function void note_request(lef_pkg::lef_in_t req);
      lef_pkg::lef_out_t res;
      longint            cur, delta, tn, nxt;
      if (req.operation == lef_pkg::OP_ENABLE) begin
        on = req.enable;
        if (!on) begin
          level = '0;
          res.brightness = '0;
          res.cause = lef_pkg::CAUSE_OFF;
          levels_q.push_back(res);
        end
      end else if (on) begin
        cur   = level;
        delta = target_level(req.rms) - cur;
        tn    = (delta > 0) ? attack : release_t;
        if (tn > lef_pkg::TENTHS_MAX) tn = lef_pkg::TENTHS_MAX;
        // signed division truncates toward zero
        nxt = cur + (delta * tn) / 10;
        if (nxt < 0) nxt = 0;
        else if (nxt > cap) nxt = cap;
        level = nxt[lef_pkg::LEVEL_WIDTH-1:0];
        res.brightness = level;
        res.cause = lef_pkg::CAUSE_SAMPLE;
        levels_q.push_back(res);
      end
    endfunction

    function void check_result(lef_pkg::lef_out_t got);
      lef_pkg::lef_out_t exp_r;
      if (levels_q.size() == 0) begin
        $error("unexpected result: brightness %0d, cause %0d", got.brightness, got.cause);
        errors++;
        return;
      end
      exp_r = levels_q.pop_front();
      if (got.brightness !== exp_r.brightness) begin
        $error("brightness: expected %0d, actual %0d", exp_r.brightness, got.brightness);
        errors++;
      end
      if (got.cause !== exp_r.cause) begin
        $error("cause: expected %0d, actual %0d", exp_r.cause, got.cause);
        errors++;
      end
    endfunction

    function int outstanding();
      return levels_q.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                cfg_we;
  logic [lef_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [lef_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  lef_pkg::lef_in_t                    in_data;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  lef_pkg::lef_out_t                   out_data;

  level_scoreboard sb = new();
  int burst_left = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int stall_left = 0;

  level_led_envelope_follower u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall: stretches of no stall, light random stall and heavy stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 160);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Result monitor and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one request, hold it until taken, then maybe open a gap
  task automatic push_request(lef_pkg::lef_in_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Drain every expected level, then let any silent request finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write
  task automatic cfg_write(lef_pkg::lef_cfg_e idx, logic [lef_pkg::CFG_DATA_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic [15:0] gate, logic [15:0] full, logic [15:0] cap,
                           logic [15:0] att, logic [15:0] rel);
    cfg_write(lef_pkg::CFG_NOISE_GATE, gate);
    cfg_write(lef_pkg::CFG_FULL_SCALE, full);
    cfg_write(lef_pkg::CFG_BRIGHTNESS_CAP, cap);
    cfg_write(lef_pkg::CFG_ATTACK_TENTHS, att);
    cfg_write(lef_pkg::CFG_RELEASE_TENTHS, rel);
    cfg_we <= 1'b0;
  endtask

  // Levels biased toward the gate, full scale and the span between them
  function automatic logic [lef_pkg::SAMPLE_WIDTH-1:0] pick_rms();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return sb.gate;
      3: return sb.gate + 16'd1;
      4: return sb.full;
      9: return 16'($urandom);
      default: return (sb.full > sb.gate) ? 16'($urandom_range(sb.gate, sb.full))
                                           : 16'($urandom);
    endcase
  endfunction

  // Tenths with the unused upper data bits filled at random
  function automatic logic [15:0] pick_tenths();
    logic [3:0] t;
    case ($urandom_range(0, 3))
      0: t = 4'd0;
      1: t = 4'd10;
      2: t = 4'($urandom_range(11, 15));
      default: t = 4'($urandom_range(0, 10));
    endcase
    return {12'($urandom), t};
  endfunction

  task automatic random_phase(int n);
    int               taken;
    lef_pkg::lef_in_t req;
    taken = 0;
    while (taken < n) begin
      req.operation = lef_pkg::OP_SAMPLE;
      req.rms       = pick_rms();
      req.enable    = 1'($urandom_range(0, 1));
      if (!sb.on) begin
        case ($urandom_range(0, 4))
          0, 1, 2: begin
            req.operation = lef_pkg::OP_ENABLE;
            req.enable    = 1'b1;
          end
          3: begin
            req.operation = lef_pkg::OP_ENABLE;
            req.enable    = 1'b0;
          end
          default: ;
        endcase
      end else if ($urandom_range(0, 19) == 0) begin
        req.operation = lef_pkg::OP_ENABLE;
      end
      // samples while disabled are dropped by the block and do not count
      if (req.operation == lef_pkg::OP_ENABLE || sb.on) taken++;
      push_request(req);
    end
  endtask

  initial begin
    logic [15:0] g, f, c;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: disabled samples, disable while off, enable twice
    push_request('{lef_pkg::OP_SAMPLE, 16'd0, 1'b1});
    push_request('{lef_pkg::OP_SAMPLE, 16'hFFFF, 1'b0});
    push_request('{lef_pkg::OP_ENABLE, 16'h1234, 1'b0});
    push_request('{lef_pkg::OP_ENABLE, 16'd0, 1'b1});
    push_request('{lef_pkg::OP_ENABLE, 16'hFFFF, 1'b1});
    // gate edge, full scale, above full scale, release, then disable, a dropped sample and re-enable
    push_request('{lef_pkg::OP_SAMPLE, 16'd500, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'd501, 1'b1});
    push_request('{lef_pkg::OP_SAMPLE, 16'd8000, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'hFFFF, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'hFFFF, 1'b1});
    push_request('{lef_pkg::OP_SAMPLE, 16'd0, 1'b0});
    push_request('{lef_pkg::OP_ENABLE, 16'd0, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'd7000, 1'b0});
    push_request('{lef_pkg::OP_ENABLE, 16'd0, 1'b1});
    wait_idle();

    // Widest map, saturating attack, full release
    configure(16'd0, 16'hFFFF, 16'd255, 16'd15, 16'd10);
    push_request('{lef_pkg::OP_SAMPLE, 16'hFFFF, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'd0, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'hFFFF, 1'b0});
    wait_idle();

    // Cap lowered below the kept level, no movement allowed
    configure(16'd0, 16'hFFFF, 16'd10, 16'd0, 16'd0);
    push_request('{lef_pkg::OP_SAMPLE, 16'hFFFF, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'd0, 1'b0});
    wait_idle();

    // Zero span
    configure(16'd1000, 16'd1000, 16'd255, 16'd10, 16'd10);
    push_request('{lef_pkg::OP_SAMPLE, 16'd2000, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'd1000, 1'b0});
    wait_idle();

    // Negative span, zero cap, tenths above ten
    configure(16'hFFFF, 16'd0, 16'd0, 16'd11, 16'd13);
    push_request('{lef_pkg::OP_SAMPLE, 16'hFFFF, 1'b0});
    push_request('{lef_pkg::OP_SAMPLE, 16'd30000, 1'b0});

    // Random settings, each applied once the block has drained
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0: g = '0;
        1: g = '1;
        default: g = 16'($urandom_range(0, 6000));
      endcase
      case ($urandom_range(0, 4))
        0: f = '1;
        1: f = 16'($urandom_range(0, g));
        default: f = g + 16'($urandom_range(1, 20000));
      endcase
      case ($urandom_range(0, 3))
        0: c = {8'($urandom), 8'd0};
        1: c = {8'($urandom), 8'd255};
        default: c = 16'($urandom);
      endcase
      configure(g, f, c, pick_tenths(), pick_tenths());
      random_phase(PHASE_ITEMS);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
src/lef_pkg.sv
src/lef_dp.sv
src/lef_ctrl.sv
src/level_led_envelope_follower.sv
test/tb_top.sv
